// ----- rtl/core/hss_pkg.sv -----
package hss_pkg;

  localparam int DEF_MAX_SIDE = 256;

  localparam int VALUE_W     = 24;
  localparam int IDX_OUT_W   = 8;
  localparam int GRID_SIDE_W = 9;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_GRID_SIDE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_ROW   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_COL   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_VALUE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_EN    = 3'd4;

  localparam logic [GRID_SIDE_W-1:0] RST_GRID_SIDE    = 9'd200;
  localparam logic [IDX_OUT_W-1:0]   RST_SOURCE_ROW   = 8'd50;
  localparam logic [IDX_OUT_W-1:0]   RST_SOURCE_COL   = 8'd50;
  localparam logic [VALUE_W-1:0]     RST_SOURCE_VALUE = 24'd85248;
  localparam logic                   RST_SOURCE_EN    = 1'b1;

  typedef struct packed {
    logic               mid_we;
    logic               up_we;
    logic [VALUE_W-1:0] mid_data;
    logic [VALUE_W-1:0] up_data;
  } hss_wr_t;

  typedef struct packed {
    logic [VALUE_W-1:0] self;
    logic [VALUE_W-1:0] east;
    logic [VALUE_W-1:0] north;
  } hss_rd_t;

  typedef struct packed {
    logic                 frame_last;
    logic [IDX_OUT_W-1:0] out_col;
    logic [IDX_OUT_W-1:0] out_row;
    logic [VALUE_W-1:0]   new_value;
  } hss_res_t;

endpackage

// ----- rtl/core/hss_line_store.sv -----
module hss_line_store import hss_pkg::*; #(
  parameter int MAX_SIDE = DEF_MAX_SIDE,
  localparam int COL_W = $clog2(MAX_SIDE)
) (
  input  logic             clk,
  input  hss_wr_t          wr,
  input  logic [COL_W-1:0] wcol,
  input  logic [COL_W-1:0] rcol,
  output hss_rd_t          rd
);

  logic [VALUE_W-1:0] mid_store [MAX_SIDE];
  logic [VALUE_W-1:0] up_store  [MAX_SIDE];

  logic [COL_W-1:0]   ecol;
  logic [VALUE_W-1:0] self_raw;
  logic [VALUE_W-1:0] east_raw;
  logic [VALUE_W-1:0] north_raw;
  logic               self_fwd;
  logic               east_fwd;
  logic               north_fwd;
  logic [VALUE_W-1:0] mid_wdata;
  logic [VALUE_W-1:0] up_wdata;

  assign ecol = (rcol == COL_W'(MAX_SIDE - 1)) ? '0 : rcol + 1'b1;

  always_ff @(posedge clk) begin
    if (wr.mid_we) begin
      mid_store[wcol] <= wr.mid_data;
    end
    self_raw <= mid_store[rcol];
    east_raw <= mid_store[ecol];
  end

  always_ff @(posedge clk) begin
    if (wr.up_we) begin
      up_store[wcol] <= wr.up_data;
    end
    north_raw <= up_store[rcol];
  end

  // A write in the same cycle as the read of that entry is forwarded.
  always_ff @(posedge clk) begin
    self_fwd  <= wr.mid_we && (wcol == rcol);
    east_fwd  <= wr.mid_we && (wcol == ecol);
    north_fwd <= wr.up_we && (wcol == rcol);
    mid_wdata <= wr.mid_data;
    up_wdata  <= wr.up_data;
  end

  assign rd.self  = self_fwd ? mid_wdata : self_raw;
  assign rd.east  = east_fwd ? mid_wdata : east_raw;
  assign rd.north = north_fwd ? up_wdata : north_raw;

endmodule

// ----- rtl/core/hss_out_fifo.sv -----
module hss_out_fifo import hss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  hss_res_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hss_res_t out_data
);

  hss_res_t   slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

// ----- rtl/core/heat_stencil_step.sv -----
// Channel  Direction  Handshake              Contents
// s_       in         s_tvalid / s_tready    tdata: cell_value; tuser: action
// m_       out        m_tvalid / m_tready    tdata: new_value, out_row, out_col; tlast
// apb      in         psel, penable, pready  register writes and reads
//
// One item is taken every clock cycle while the output queue has room; a result
// is registered in the output queue before it appears on m_.
// The two row stores are read ahead at the next column, so the
// stencil needs no stall per item.
// Reset is synchronous and clears the counters, the registers and the output
// queue; the row stores are not cleared.
// s_tready is low during reset and while both entries of the output queue are occupied.
module heat_stencil_step import hss_pkg::*; #(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [23:0] cell_value
  input  logic                  s_tuser,   // [0] action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [23:0] new_value, [31:24] out_row, [39:32] out_col
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int COL_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > GRID_SIDE_W) ? SIDE_W : GRID_SIDE_W;
  localparam int RC_W   = (COL_W > IDX_OUT_W) ? COL_W : IDX_OUT_W;

  logic [GRID_SIDE_W-1:0] grid_side;
  logic [IDX_OUT_W-1:0]   source_row;
  logic [IDX_OUT_W-1:0]   source_col;
  logic [VALUE_W-1:0]     source_value;
  logic                   source_enable;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 restart;

  logic [CMP_W-1:0]  gs_ext;
  logic [SIDE_W-1:0] side;

  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [COL_W-1:0]  rd_col;
  logic [SIDE_W-1:0] row;
  logic [SIDE_W-1:0] row_next;

  logic               fifo_ready;
  logic               accept;
  logic               draining;
  logic               col_last;
  logic               works;
  logic               emit;
  logic [SIDE_W-1:0]  res_row;
  logic [COL_W-1:0]   res_row_c;
  logic [VALUE_W-1:0] cell_data;
  logic [VALUE_W-1:0] west;
  logic [VALUE_W-1:0] nb_n;
  logic [VALUE_W-1:0] nb_s;
  logic [VALUE_W-1:0] nb_w;
  logic [VALUE_W-1:0] nb_e;
  logic [VALUE_W+1:0] sum;
  logic               hit;

  hss_wr_t  wr;
  hss_rd_t  rd;
  hss_res_t res;
  hss_res_t out_res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign restart = cfg_wr && (reg_idx == REG_GRID_SIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side     <= RST_GRID_SIDE;
      source_row    <= RST_SOURCE_ROW;
      source_col    <= RST_SOURCE_COL;
      source_value  <= RST_SOURCE_VALUE;
      source_enable <= RST_SOURCE_EN;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GRID_SIDE:    grid_side     <= pwdata[GRID_SIDE_W-1:0];
        REG_SOURCE_ROW:   source_row    <= pwdata[IDX_OUT_W-1:0];
        REG_SOURCE_COL:   source_col    <= pwdata[IDX_OUT_W-1:0];
        REG_SOURCE_VALUE: source_value  <= pwdata[VALUE_W-1:0];
        REG_SOURCE_EN:    source_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_SIDE:    prdata = APB_DATA_W'(grid_side);
      REG_SOURCE_ROW:   prdata = APB_DATA_W'(source_row);
      REG_SOURCE_COL:   prdata = APB_DATA_W'(source_col);
      REG_SOURCE_VALUE: prdata = APB_DATA_W'(source_value);
      REG_SOURCE_EN:    prdata = APB_DATA_W'(source_enable);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    gs_ext = CMP_W'(grid_side);
    if (gs_ext == '0) begin
      side = SIDE_W'(1);
    end else if (gs_ext > CMP_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(gs_ext);
    end
  end

  assign s_tready = fifo_ready && !rst;
  assign accept   = s_tvalid && s_tready;
  assign draining = (row >= side);
  assign col_last = ((SIDE_W'(col) + SIDE_W'(1)) >= side);
  assign works    = accept && (s_tuser ? draining : !draining);
  assign emit     = works && (draining || (row != '0));

  always_comb begin
    col_next = col;
    row_next = row;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (works) begin
      if (col_last) begin
        col_next = '0;
        row_next = draining ? '0 : row + SIDE_W'(1);
      end else begin
        col_next = col + COL_W'(1);
      end
    end
  end

  assign rd_col = rst ? '0 : col_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (works) begin
      west <= rd.self;
    end
  end

  assign cell_data   = s_tdata[VALUE_W-1:0];
  assign wr.mid_we   = works && !draining;
  assign wr.mid_data = cell_data;
  assign wr.up_we    = emit;
  assign wr.up_data  = rd.self;

  hss_line_store #(
    .MAX_SIDE(MAX_SIDE)
  ) u_line_store (
    .clk (clk),
    .wr  (wr),
    .wcol(col),
    .rcol(rd_col),
    .rd  (rd)
  );

  assign res_row   = draining ? side - SIDE_W'(1) : row - SIDE_W'(1);
  assign res_row_c = COL_W'(res_row);

  assign nb_n = (res_row == '0) ? rd.self : rd.north;
  assign nb_s = draining ? rd.self : cell_data;
  assign nb_w = (col == '0) ? rd.self : west;
  assign nb_e = col_last ? rd.self : rd.east;

  assign sum = (VALUE_W + 2)'(nb_n) + (VALUE_W + 2)'(nb_s)
             + (VALUE_W + 2)'(nb_w) + (VALUE_W + 2)'(nb_e);

  assign hit = source_enable && (RC_W'(res_row_c) == RC_W'(source_row))
               && (RC_W'(col) == RC_W'(source_col));

  assign res.new_value  = hit ? source_value : sum[VALUE_W+1:2];
  assign res.out_row    = IDX_OUT_W'(res_row_c);
  assign res.out_col    = IDX_OUT_W'(col);
  assign res.frame_last = draining && col_last;

  hss_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (emit),
    .in_ready (fifo_ready),
    .in_data  (res),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_res)
  );

  assign m_tdata = {out_res.out_col, out_res.out_row, out_res.new_value};
  assign m_tlast = out_res.frame_last;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import hss_pkg::*;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam int   LIMIT_CYCLES = 100_000;
  localparam int   COL_W = $clog2(DEF_MAX_SIDE);
  localparam logic [VALUE_W-1:0] HOTTEST = {VALUE_W{1'b1}};

  typedef struct packed {
    logic               drain;
    logic [VALUE_W-1:0] value;
  } grid_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [23:0] cell_value
  logic                  s_tuser = 1'b0; // [0] action
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [23:0] new_value, [31:24] out_row, [39:32] out_col
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  heat_stencil_step DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Predictor state and its copy of the registers.
  logic [VALUE_W-1:0]     upper_row [DEF_MAX_SIDE];
  logic [VALUE_W-1:0]     middle_row [DEF_MAX_SIDE];
  int                     in_col = 0;
  int                     in_row = 0;
  int                     drain_col = 0;
  logic [GRID_SIDE_W-1:0] side_reg = RST_GRID_SIDE;
  logic [IDX_OUT_W-1:0]   src_row = RST_SOURCE_ROW;
  logic [IDX_OUT_W-1:0]   src_col = RST_SOURCE_COL;
  logic [VALUE_W-1:0]     src_value = RST_SOURCE_VALUE;
  logic                   src_en = RST_SOURCE_EN;

  grid_item_t pending_cells [$];
  hss_res_t   awaited_cells [$];
  grid_item_t offered_item;
  int         items_outstanding = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic       s_taken = 1'b0;
  int         hold_left = 0;
  logic       pressure_done = 1'b0;
  logic       steady;

  assign steady = cycle_count >= 600 && cycle_count < 1000;

  function automatic int side_in_use();
    if (side_reg == 0) return 1;
    if (side_reg > DEF_MAX_SIDE) return DEF_MAX_SIDE;
    return int'(side_reg);
  endfunction

  function automatic hss_res_t stencil_cell(input int r, input int c, input int g,
                                            input logic [VALUE_W-1:0] south,
                                            input logic last);
    logic [VALUE_W-1:0] self_v;
    logic [VALUE_W-1:0] north;
    logic [VALUE_W-1:0] west;
    logic [VALUE_W-1:0] east;
    logic [VALUE_W+1:0] total;
    hss_res_t           res;
    self_v = middle_row[COL_W'(c)];
    north = (r == 0) ? self_v : upper_row[COL_W'(c)];
    west = (c == 0) ? self_v : upper_row[COL_W'(c - 1)];
    east = (c + 1 >= g) ? self_v : middle_row[COL_W'(c + 1)];
    total = (VALUE_W + 2)'(north) + (VALUE_W + 2)'(south)
          + (VALUE_W + 2)'(west) + (VALUE_W + 2)'(east);
    res.new_value = total[VALUE_W+1:2];
    if (src_en && r == src_row && c == src_col) res.new_value = src_value;
    res.out_row = r[IDX_OUT_W-1:0];
    res.out_col = c[IDX_OUT_W-1:0];
    res.frame_last = last;
    upper_row[COL_W'(c)] = self_v;
    return res;
  endfunction

  function automatic void advance_stencil(input grid_item_t it);
    int   g;
    logic last;
    g = side_in_use();
    if (it.drain == ACT_PUSH) begin
      if (in_row >= g || in_col >= g) return;
      if (in_row != 0) awaited_cells.push_back(stencil_cell(in_row - 1, in_col, g, it.value, 1'b0));
      middle_row[COL_W'(in_col)] = it.value;
      in_col++;
      if (in_col >= g) begin
        in_col = 0;
        in_row++;
      end
    end else begin
      if (in_row < g || drain_col >= g) return;
      last = drain_col + 1 >= g;
      awaited_cells.push_back(stencil_cell(g - 1, drain_col, g,
                                           middle_row[COL_W'(drain_col)], last));
      if (last) begin
        in_row = 0;
        in_col = 0;
        drain_col = 0;
      end else begin
        drain_col++;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("Mismatch in %s at cycle %0d: got %0h, expected %0h", what, cycle_count, got, want);
  endtask

  always @(posedge clk) begin
    hss_res_t got;
    hss_res_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst) begin
      s_taken <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata};
        if (awaited_cells.size() == 0) begin
          report_mismatch("unexpected transfer", m_tdata[31:0], '0);
        end else begin
          want = awaited_cells.pop_front();
          if (got.new_value !== want.new_value)
            report_mismatch("new_value", 32'(got.new_value), 32'(want.new_value));
          if (got.out_row !== want.out_row)
            report_mismatch("out_row", 32'(got.out_row), 32'(want.out_row));
          if (got.out_col !== want.out_col)
            report_mismatch("out_col", 32'(got.out_col), 32'(want.out_col));
          if (got.frame_last !== want.frame_last)
            report_mismatch("frame_last", 32'(got.frame_last), 32'(want.frame_last));
        end
      end
      if (s_tvalid && s_tready) begin
        advance_stencil('{s_tuser, s_tdata});
        items_outstanding--;
      end
      s_taken <= s_tvalid && s_tready;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (pending_cells.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
        offered_item = pending_cells.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= offered_item.value;
        s_tuser <= offered_item.drain;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && m_tvalid && pending_cells.size() > 40) begin
      pressure_done <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || $urandom_range(99) >= 30;
    end
  end

  function automatic logic [VALUE_W-1:0] random_cell();
    case ($urandom_range(7))
      0: return '0;
      1: return HOTTEST;
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  task automatic queue_item(input logic act, input logic [VALUE_W-1:0] v);
    pending_cells.push_back('{act, v});
    items_outstanding++;
  endtask

  task automatic queue_frame(input int g, input int noise_pct);
    for (int i = 0; i < g * g; i++) begin
      if ($urandom_range(99) < noise_pct) queue_item(ACT_DRAIN, random_cell());
      queue_item(ACT_PUSH, random_cell());
    end
    for (int i = 0; i < g; i++) begin
      if ($urandom_range(99) < noise_pct) queue_item(ACT_PUSH, random_cell());
      queue_item(ACT_DRAIN, random_cell());
    end
  endtask

  task automatic settle();
    while (items_outstanding != 0 || awaited_cells.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GRID_SIDE: begin
        side_reg = value[GRID_SIDE_W-1:0];
        in_row = 0;
        in_col = 0;
        drain_col = 0;
      end
      REG_SOURCE_ROW:   src_row = value[IDX_OUT_W-1:0];
      REG_SOURCE_COL:   src_col = value[IDX_OUT_W-1:0];
      REG_SOURCE_VALUE: src_value = value[VALUE_W-1:0];
      REG_SOURCE_EN:    src_en = value[0];
      default: ;
    endcase
  endtask

  initial begin
    int g;
    int eff;
    int n;
    int random_items;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_register(REG_GRID_SIDE, 3);
    write_register(REG_SOURCE_ROW, 1);
    write_register(REG_SOURCE_COL, 1);
    write_register(REG_SOURCE_VALUE, 32'(HOTTEST));
    write_register(REG_SOURCE_EN, 1);
    queue_item(ACT_DRAIN, HOTTEST);
    queue_item(ACT_PUSH, 0);
    queue_item(ACT_PUSH, HOTTEST);
    queue_item(ACT_PUSH, 0);
    queue_item(ACT_PUSH, HOTTEST);
    queue_item(ACT_PUSH, HOTTEST);
    queue_item(ACT_DRAIN, 0);
    queue_item(ACT_PUSH, 0);
    queue_item(ACT_PUSH, 24'h123456);
    queue_item(ACT_PUSH, HOTTEST);
    queue_item(ACT_PUSH, 0);
    queue_item(ACT_PUSH, HOTTEST);
    queue_item(ACT_DRAIN, 24'hABCDEF);
    queue_item(ACT_DRAIN, 0);
    queue_item(ACT_DRAIN, HOTTEST);
    settle();
    write_register(REG_GRID_SIDE, 0);
    write_register(REG_SOURCE_EN, 0);
    queue_item(ACT_PUSH, 24'h5A5A5A);
    queue_item(ACT_PUSH, HOTTEST);
    queue_item(ACT_DRAIN, 0);
    settle();
    write_register(REG_GRID_SIDE, 8);
    queue_frame(8, 0);

    random_items = 0;
    while (random_items < 130) begin
      settle();
      n = $urandom_range(99);
      if (n < 5) g = 0;
      else if (n < 10) g = 1;
      else g = $urandom_range(2, 10);
      eff = (g == 0) ? 1 : g;
      write_register(REG_GRID_SIDE, g);
      if ($urandom_range(1)) write_register(REG_SOURCE_EN, $urandom_range(1));
      if ($urandom_range(2) == 0) write_register(REG_SOURCE_VALUE, 32'(random_cell()));
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: begin
            write_register(REG_SOURCE_ROW, $urandom_range(eff - 1));
            write_register(REG_SOURCE_COL, $urandom_range(eff - 1));
          end
          1: begin
            write_register(REG_SOURCE_ROW, 0);
            write_register(REG_SOURCE_COL, 0);
          end
          2: begin
            write_register(REG_SOURCE_ROW, 255);
            write_register(REG_SOURCE_COL, 255);
          end
          default: begin
            write_register(REG_SOURCE_ROW, $urandom_range(255));
            write_register(REG_SOURCE_COL, $urandom_range(255));
          end
        endcase
      end
      n = items_outstanding;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, eff * eff + eff))
          queue_item(($urandom_range(4) == 0) ? ACT_DRAIN : ACT_PUSH, random_cell());
      end else begin
        queue_frame(eff, 5);
        if ($urandom_range(3) == 0) queue_frame(eff, 5);
      end
      random_items += items_outstanding - n;
    end

    settle();
    write_register(REG_GRID_SIDE, 511);
    write_register(REG_SOURCE_ROW, 1);
    write_register(REG_SOURCE_COL, 0);
    write_register(REG_SOURCE_VALUE, 32'(HOTTEST));
    write_register(REG_SOURCE_EN, 1);
    repeat (DEF_MAX_SIDE + 10) queue_item(ACT_PUSH, random_cell());

    settle();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/hss_pkg.sv
rtl/core/hss_line_store.sv
rtl/core/hss_out_fifo.sv
rtl/core/heat_stencil_step.sv
test/testbench.sv
